>>> src/espl_pkg.sv
// ----------------------------------------------------------------------------
// espl_pkg
// Shared types and constants of the encoder speed PID loop.
// ----------------------------------------------------------------------------
package espl_pkg;

	localparam int DIV_W   = 72;
	localparam int DVSR_W  = 24;
	localparam int DIV_CNT = DIV_W / 2;
	localparam int CNT_W   = $clog2(DIV_CNT + 1);

	localparam int MUL_A_W = 25;
	localparam int MUL_B_W = 28;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam logic [23:0] SPEED_SCALE = 24'd15360000;
	localparam logic [23:0] ITERM_DIV   = 24'd1000;
	localparam logic [23:0] DUTY_FULL   = 24'd25600;

	localparam logic signed [63:0] INTEG_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [63:0] INTEG_MIN = -64'sh0000_8000_0000_0000;
	localparam logic signed [63:0] DUTY_MAX  = 64'sd25600;
	localparam logic signed [63:0] DUTY_MIN  = -64'sd25600;

	localparam logic [2:0] KIND_TICK    = 3'd0;
	localparam logic [2:0] KIND_ESTOP   = 3'd1;
	localparam logic [2:0] KIND_ENABLE  = 3'd2;
	localparam logic [2:0] KIND_DISABLE = 3'd3;
	localparam logic [2:0] KIND_SETSPD  = 3'd4;

	localparam logic [2:0] REG_KP  = 3'd0;
	localparam logic [2:0] REG_KI  = 3'd1;
	localparam logic [2:0] REG_KD  = 3'd2;
	localparam logic [2:0] REG_DUP = 3'd3;
	localparam logic [2:0] REG_DLO = 3'd4;
	localparam logic [2:0] REG_TP  = 3'd5;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [DVSR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

>>> src/encoder_speed_pid_loop.sv
// ----------------------------------------------------------------------------
// encoder_speed_pid_loop
// Encoder speed PID loop with integrator clamp and PWM compare output.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one item: a control tick with a
//   shaft angle, or a command (stop, enable, disable, set speed). Every item
//   gives exactly one result on the output channel (out_valid/out_ready).
//   The user writes gains, duty limits and timer period over the APB port only
//   while the block is idle, which it leaves unchecked; pready is always high.
//   One item is in work at a time; in_ready is high only while idle. A command,
//   a stop or a tick while disabled only computes the compare value; an
//   enabled tick first computes speed, error, the P and D terms, the two
//   integrator limits (skipped with integ_gain zero) and the integral term.
//   in_ready returns with the result. The shared divider gives two quotient
//   bits per cycle over 72 bits, for the two integrator limits, the integral
//   term and the compare value; one shared multiplier serves all products.
//   The result waits in an output register; the next item is taken meanwhile
//   and finishes when the receiver has taken the earlier result.
//   Reset loads the default gains and limits, clears loop state, disables the
//   loop and releases the emergency stop latch.
// ----------------------------------------------------------------------------
module encoder_speed_pid_loop
	import espl_pkg::*;
#(
	parameter int ANGLE_BITS = 14
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0]            kind,
	input  logic [ANGLE_BITS-1:0] shaft_angle,
	input  logic signed [23:0]    new_setpoint,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [15:0]    duty,
	output logic [15:0]           compare_value,
	output logic signed [23:0]    measured_speed,
	output logic                  running,
	output logic                  stopped,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [4:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam int AW = ANGLE_BITS;

	typedef enum logic [4:0] {
		S_IDLE, S_SPD, S_SPD2, S_ERR, S_P, S_P2, S_D2, S_LIM0, S_LIM1, S_LIM2,
		S_I0, S_I1, S_I2, S_I3, S_OUT, S_CMP, S_CMP1, S_CMP2, S_DONE
	} state_t;

	state_t st_q;

	logic [23:0]        kp_q, ki_q, kd_q;
	logic signed [15:0] dup_q, dlo_q;
	logic [15:0]        tp_q;

	logic [AW-1:0]      last_angle_q;
	logic signed [25:0] last_error_q, err_q;
	logic signed [47:0] integ_q;
	logic signed [23:0] target_q, speed_q;
	logic               loop_on_q, estop_q;
	logic signed [15:0] last_duty_q;

	logic [AW-1:0]      mag_q;
	logic               neg_q;
	logic signed [51:0] p_q;
	logic signed [63:0] d_q, t_q, itmp_q, sum_q;
	logic [47:0]        acc_q;
	logic               lim_lo_q, nneg_q;
	logic [15:0]        cmp_q;

	logic               out_valid_q;
	logic signed [15:0] duty_q;
	logic [15:0]        cmpo_q;
	logic signed [23:0] speedo_q;
	logic               running_q, stopped_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;
	div_req_t                  dreq;
	div_rsp_t                  drsp;

	espl_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_q(mul_p));
	espl_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
		if (v > INTEG_MAX) return INTEG_MAX[47:0];
		if (v < INTEG_MIN) return INTEG_MIN[47:0];
		return v[47:0];
	endfunction

	function automatic logic signed [63:0] x1000(input logic signed [63:0] v);
		return (v <<< 10) - (v <<< 4) - (v <<< 3);
	endfunction

	logic signed [AW+1:0] dl, dw;
	logic [AW-1:0]        dmag;
	logic [47:0]          iabs;
	logic [14:0]          duty_mag;
	logic signed [63:0]   lim64, nval, qsig, integ64, lo_v, sadj, sh, o1, o2, o3;
	logic [63:0]          nabs;
	logic [23:0]          sp_raw;
	logic signed [26:0]   ediff;
	logic [71:0]          ifull;
	logic                 wr_en;

	always_comb begin
		dl = $signed({2'b00, shaft_angle}) - $signed({2'b00, last_angle_q});
		if (dl > $signed((AW+2)'(1 << (AW-1))))
			dw = dl - $signed((AW+2)'(1 << AW));
		else if (dl < -$signed((AW+2)'(1 << (AW-1))))
			dw = dl + $signed((AW+2)'(1 << AW));
		else
			dw = dl;
		dmag = dw[AW+1] ? AW'(-dw) : AW'(dw);

		iabs     = integ_q[47] ? 48'(-integ_q) : 48'(integ_q);
		duty_mag = last_duty_q[15] ? 15'(-last_duty_q) : 15'(last_duty_q);
		ediff    = 27'(err_q) - 27'(last_error_q);
		sp_raw   = mul_p[AW +: 24];

		lim64 = lim_lo_q ? 64'(dlo_q) : 64'(dup_q);
		nval  = x1000(t_q);
		nabs  = nval[63] ? 64'(-nval) : 64'(nval);
		qsig  = nneg_q ? -$signed(drsp.quotient[63:0]) : $signed(drsp.quotient[63:0]);
		integ64 = 64'(integ_q);
		lo_v  = (itmp_q < qsig) ? qsig : itmp_q;
		ifull = {24'b0, acc_q} + {mul_p[47:0], 24'b0};

		sadj = sum_q + (sum_q[63] ? 64'sd65535 : 64'sd0);
		sh   = sadj >>> 16;
		o1   = (sh > 64'(dup_q)) ? 64'(dup_q) : sh;
		o2   = (o1 < 64'(dlo_q)) ? 64'(dlo_q) : o1;
		o3   = (o2 > DUTY_MAX) ? DUTY_MAX : ((o2 < DUTY_MIN) ? DUTY_MIN : o2);

		mul_a = '0;
		mul_b = '0;
		case (st_q)
			S_SPD: begin
				mul_a = MUL_A_W'(SPEED_SCALE);
				mul_b = MUL_B_W'(mag_q);
			end
			S_P: begin
				mul_a = MUL_A_W'(kp_q);
				mul_b = MUL_B_W'(err_q);
			end
			S_P2: begin
				mul_a = MUL_A_W'(kd_q);
				mul_b = MUL_B_W'(ediff);
			end
			S_I0: begin
				mul_a = MUL_A_W'(ki_q);
				mul_b = MUL_B_W'(iabs[23:0]);
			end
			S_I1: begin
				mul_a = MUL_A_W'(ki_q);
				mul_b = MUL_B_W'(iabs[47:24]);
			end
			S_CMP: begin
				mul_a = MUL_A_W'(tp_q);
				mul_b = MUL_B_W'(duty_mag);
			end
			default: ;
		endcase

		dreq.start    = 1'b0;
		dreq.dividend = '0;
		dreq.divisor  = ITERM_DIV;
		case (st_q)
			S_LIM1: begin
				dreq.start    = 1'b1;
				dreq.dividend = DIV_W'(nabs);
				dreq.divisor  = ki_q;
			end
			S_I2: begin
				dreq.start    = 1'b1;
				dreq.dividend = ifull;
				dreq.divisor  = ITERM_DIV;
			end
			S_CMP1: begin
				dreq.start    = 1'b1;
				dreq.dividend = DIV_W'($unsigned(mul_p));
				dreq.divisor  = DUTY_FULL;
			end
			default: ;
		endcase
	end

	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q  <= 24'd32768;
			ki_q  <= 24'd6554;
			kd_q  <= 24'd3277;
			dup_q <= 16'sd25600;
			dlo_q <= -16'sd25600;
			tp_q  <= 16'd8399;
		end else if (wr_en) begin
			case (paddr[4:2])
				REG_KP:  kp_q  <= pwdata[23:0];
				REG_KI:  ki_q  <= pwdata[23:0];
				REG_KD:  kd_q  <= pwdata[23:0];
				REG_DUP: dup_q <= pwdata[15:0];
				REG_DLO: dlo_q <= pwdata[15:0];
				REG_TP:  tp_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_KP:  prdata = {8'b0, kp_q};
			REG_KI:  prdata = {8'b0, ki_q};
			REG_KD:  prdata = {8'b0, kd_q};
			REG_DUP: prdata = {16'b0, dup_q};
			REG_DLO: prdata = {16'b0, dlo_q};
			REG_TP:  prdata = {16'b0, tp_q};
			default: prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			last_angle_q <= '0;
			last_error_q <= '0;
			integ_q      <= '0;
			target_q     <= '0;
			loop_on_q    <= 1'b0;
			estop_q      <= 1'b0;
			last_duty_q  <= '0;
			lim_lo_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && st_q != S_DONE) out_valid_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						speed_q <= '0;
						if (estop_q || kind == KIND_ESTOP) begin
							estop_q     <= 1'b1;
							last_duty_q <= '0;
							integ_q     <= '0;
							loop_on_q   <= 1'b0;
							st_q        <= S_CMP;
						end else begin
							case (kind)
								KIND_TICK: begin
									if (loop_on_q) begin
										last_angle_q <= shaft_angle;
										mag_q        <= dmag;
										neg_q        <= dw[AW+1];
										st_q         <= S_SPD;
									end else begin
										st_q <= S_CMP;
									end
								end
								KIND_ENABLE: begin
									loop_on_q <= 1'b1;
									st_q      <= S_CMP;
								end
								KIND_DISABLE: begin
									loop_on_q   <= 1'b0;
									last_duty_q <= '0;
									st_q        <= S_CMP;
								end
								KIND_SETSPD: begin
									target_q <= new_setpoint;
									st_q     <= S_CMP;
								end
								default: st_q <= S_CMP;
							endcase
						end
					end
				end
				S_SPD: st_q <= S_SPD2;
				S_SPD2: begin
					speed_q <= neg_q ? -$signed(sp_raw) : $signed(sp_raw);
					st_q    <= S_ERR;
				end
				S_ERR: begin
					err_q <= 26'(target_q) - 26'(speed_q);
					st_q  <= S_P;
				end
				S_P: begin
					integ_q <= sat48(64'(integ_q) + 64'(err_q));
					st_q    <= S_P2;
				end
				S_P2: begin
					p_q  <= mul_p[51:0];
					st_q <= S_D2;
				end
				S_D2: begin
					d_q          <= x1000(64'(mul_p));
					last_error_q <= err_q;
					lim_lo_q     <= 1'b0;
					st_q         <= (ki_q == '0) ? S_I0 : S_LIM0;
				end
				S_LIM0: begin
					t_q  <= (lim64 <<< 16) - 64'(p_q);
					st_q <= S_LIM1;
				end
				S_LIM1: begin
					nneg_q <= nval[63];
					st_q   <= S_LIM2;
				end
				S_LIM2: begin
					if (drsp.done) begin
						if (!lim_lo_q) begin
							itmp_q   <= (integ64 > qsig) ? qsig : integ64;
							lim_lo_q <= 1'b1;
							st_q     <= S_LIM0;
						end else begin
							integ_q <= sat48(lo_v);
							st_q    <= S_I0;
						end
					end
				end
				S_I0: begin
					nneg_q <= integ_q[47];
					st_q   <= S_I1;
				end
				S_I1: begin
					acc_q <= mul_p[47:0];
					st_q  <= S_I2;
				end
				S_I2: st_q <= S_I3;
				S_I3: begin
					if (drsp.done) begin
						sum_q <= 64'(p_q) + qsig + d_q;
						st_q  <= S_OUT;
					end
				end
				S_OUT: begin
					last_duty_q <= o3[15:0];
					st_q        <= S_CMP;
				end
				S_CMP:  st_q <= S_CMP1;
				S_CMP1: begin
					nneg_q <= 1'b0;
					st_q   <= S_CMP2;
				end
				S_CMP2: begin
					if (drsp.done) begin
						cmp_q <= drsp.quotient[15:0];
						st_q  <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						duty_q      <= last_duty_q;
						cmpo_q      <= cmp_q;
						speedo_q    <= speed_q;
						running_q   <= loop_on_q;
						stopped_q   <= estop_q;
						st_q        <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready       = (st_q == S_IDLE);
	assign out_valid      = out_valid_q;
	assign duty           = duty_q;
	assign compare_value  = cmpo_q;
	assign measured_speed = speedo_q;
	assign running        = running_q;
	assign stopped        = stopped_q;

`ifndef SYNTH
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while busy");
	a_stop_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stopped |-> !running && duty == 16'sd0)
		else $error("stop latched with loop running");
	a_duty_rng: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> duty <= 16'sd25600 && duty >= -16'sd25600)
		else $error("duty out of range");
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		dreq.start |-> !drsp.busy)
		else $error("divider started while busy");
	a_stop_hold: assert property (@(posedge clk) disable iff (!arst_n)
		estop_q |=> estop_q)
		else $error("stop latch released");
`endif

endmodule

>>> src/espl_mul.sv
// ----------------------------------------------------------------------------
// espl_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module espl_mul
	import espl_pkg::*;
(
	input  logic                      clk,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [MUL_P_W-1:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

endmodule

>>> src/espl_div.sv
// ----------------------------------------------------------------------------
// espl_div
// Iterative unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module espl_div
	import espl_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DVSR_W-1:0] rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DVSR_W-1:0] dvsr_q;
	logic [DVSR_W-1:0] rem_n;
	logic [DIV_W-1:0]  quo_n;

	always_comb begin
		logic [DVSR_W:0] t;
		rem_n = rem_q;
		quo_n = quo_q;
		for (int k = 0; k < 2; k++) begin
			t     = {rem_n, quo_n[DIV_W-1]};
			quo_n = {quo_n[DIV_W-2:0], 1'b0};
			if (t >= {1'b0, dvsr_q}) begin
				rem_n    = DVSR_W'(t - {1'b0, dvsr_q});
				quo_n[0] = 1'b1;
			end else begin
				rem_n = t[DVSR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_CNT);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rem_q  <= '0;
			quo_q  <= req.dividend;
			dvsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the encoder speed PID loop. A built-in predictor
// tracks angle, error, integrator, target and latch state and computes the
// result of every accepted item; results are compared field by field in
// order. Random bursts and gaps on the input, random stalls on the output,
// gain and limit settings changed over APB between phases.
// ----------------------------------------------------------------------------
module tb_top
	import espl_pkg::*;
();

	typedef struct {
		logic signed [15:0] duty;
		logic [15:0]        cmp;
		logic signed [23:0] spd;
		logic               run;
		logic               stp;
	} pid_res_t;

	class pid_scoreboard;
		pid_res_t    pending[$];
		int          errors;
		longint      kp, ki, kd, dup, dlo, tper;
		longint      prev_angle, prev_err, integ, target, held_duty;
		bit          loop_en, latched;

		function void reset_state();
			kp = 32768; ki = 6554; kd = 3277; dup = 25600; dlo = -25600; tper = 8399;
			prev_angle = 0; prev_err = 0; integ = 0; target = 0; held_duty = 0;
			loop_en = 0; latched = 0; errors = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] v);
			case (idx)
				REG_KP:  kp = v[23:0];
				REG_KI:  ki = v[23:0];
				REG_KD:  kd = v[23:0];
				REG_DUP: dup = $signed(v[15:0]);
				REG_DLO: dlo = $signed(v[15:0]);
				REG_TP:  tper = v[15:0];
				default: ;
			endcase
		endfunction

		function longint sat48(longint v);
			longint mx, mn;
			mx = (longint'(1) <<< 47) - 1;
			mn = -(longint'(1) <<< 47);
			if (v > mx) return mx;
			if (v < mn) return mn;
			return v;
		endfunction

		function longint tick(longint ang, output longint spd);
			longint dlt, mag, err, p, i, d, hi, lo, o;
			dlt = ang - prev_angle;
			if (dlt > 8192) dlt -= 16384;
			else if (dlt < -8192) dlt += 16384;
			prev_angle = ang;
			mag = dlt < 0 ? -dlt : dlt;
			spd = (mag * 15360000) >>> 14;
			if (dlt < 0) spd = -spd;
			err = target - spd;
			p = kp * err;
			integ = sat48(integ + err);
			if (ki != 0) begin
				hi = ((dup * 65536) - p) * 1000 / ki;
				lo = ((dlo * 65536) - p) * 1000 / ki;
				if (integ > hi) integ = hi;
				if (integ < lo) integ = lo;
				integ = sat48(integ);
			end
			i = ki * integ / 1000;
			d = kd * (err - prev_err) * 1000;
			prev_err = err;
			o = (p + i + d) / 65536;
			if (o > dup) o = dup;
			if (o < dlo) o = dlo;
			if (o > 25600) o = 25600;
			if (o < -25600) o = -25600;
			return o;
		endfunction

		function void note_item(logic [2:0] k, logic [13:0] ang, logic signed [23:0] sp);
			longint spd, mag;
			pid_res_t r;
			spd = 0;
			if (k == KIND_ESTOP) latched = 1;
			if (latched) begin
				held_duty = 0; integ = 0; loop_en = 0;
			end else if (k == KIND_TICK) begin
				if (loop_en) held_duty = tick(ang, spd);
			end else if (k == KIND_ENABLE) loop_en = 1;
			else if (k == KIND_DISABLE) begin
				loop_en = 0; held_duty = 0;
			end else if (k == KIND_SETSPD) target = sp;
			mag = held_duty < 0 ? -held_duty : held_duty;
			r.duty = 16'(held_duty);
			r.cmp = 16'(mag * tper / 25600);
			r.spd = 24'(spd);
			r.run = loop_en;
			r.stp = latched;
			pending.push_back(r);
		endfunction

		function void check_result(pid_res_t a);
			pid_res_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result duty %0d", $time, a.duty);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.duty !== e.duty) begin
				$display("%0t: duty exp %0d got %0d", $time, e.duty, a.duty); errors++;
			end
			if (a.cmp !== e.cmp) begin
				$display("%0t: compare exp %0d got %0d", $time, e.cmp, a.cmp); errors++;
			end
			if (a.spd !== e.spd) begin
				$display("%0t: speed exp %0d got %0d", $time, e.spd, a.spd); errors++;
			end
			if (a.run !== e.run) begin
				$display("%0t: running exp %0b got %0b", $time, e.run, a.run); errors++;
			end
			if (a.stp !== e.stp) begin
				$display("%0t: stopped exp %0b got %0b", $time, e.stp, a.stp); errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [2:0] kind;
	logic [13:0] shaft_angle;
	logic signed [23:0] new_setpoint;
	logic signed [15:0] duty;
	logic [15:0] compare_value;
	logic signed [23:0] measured_speed;
	logic running, stopped;
	logic psel, penable, pwrite, pready;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;

	pid_scoreboard sb;
	int cycles;
	logic [13:0] cur_angle;

	encoder_speed_pid_loop uut (.*);

	always begin
		clk = 1'b0; #5; clk = 1'b1; #5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		pid_res_t r;
		if (arst_n && out_valid && out_ready) begin
			r.duty = duty; r.cmp = compare_value; r.spd = measured_speed;
			r.run = running; r.stp = stopped;
			sb.check_result(r);
		end
		if (arst_n && in_valid && in_ready)
			sb.note_item(kind, shaft_angle, new_setpoint);
	end

	// receiver stall pattern
	always @(posedge clk) begin
		case (($time / 4000) % 3)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			default: out_ready <= ($urandom_range(0, 1) == 0);
		endcase
	end

	task automatic reg_write(logic [2:0] idx, logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.set_reg(idx, v);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic send(logic [2:0] k, logic [13:0] ang, logic signed [23:0] sp);
		in_valid <= 1'b1; kind <= k; shaft_angle <= ang; new_setpoint <= sp;
		do @(posedge clk); while (!in_ready);
		if ($urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 60)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic random_item();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 70) begin
			cur_angle = cur_angle + 14'($urandom_range(0, 1) ? $urandom_range(0, 400)
				- 200 : $urandom);
			send(KIND_TICK, cur_angle, 24'($urandom));
		end else if (sel < 80) send(KIND_SETSPD, 14'($urandom), $urandom_range(0, 1) ?
			24'($signed($urandom_range(0, 200000)) - 100000) : 24'($urandom));
		else if (sel < 88) send(KIND_ENABLE, 14'($urandom), 24'($urandom));
		else if (sel < 92) send(KIND_DISABLE, 14'($urandom), 24'($urandom));
		else send(3'($urandom_range(5, 7)), 14'($urandom), 24'($urandom));
	endtask

	task automatic random_regs(int ph);
		reg_write(REG_KP, ph == 1 ? 32'hFFFFFF : ph == 2 ? 0 : $urandom_range(0, 200000));
		reg_write(REG_KI, ph == 2 ? 0 : ph == 1 ? 32'hFFFFFF : $urandom_range(0, 50000));
		reg_write(REG_KD, ph == 1 ? 32'hFFFFFF : ph == 2 ? 0 : $urandom_range(0, 20000));
		reg_write(REG_DUP, ph == 1 ? 32'(-25600) : 32'($urandom_range(0, 51200) - 25600));
		reg_write(REG_DLO, ph == 1 ? 32'(25600) : 32'($urandom_range(0, 51200) - 25600));
		reg_write(REG_TP, ph == 1 ? 32'hFFFF : ph == 2 ? 0 : $urandom);
	endtask

	initial begin
		sb = new();
		sb.reset_state();
		cur_angle = 0;
		arst_n = 1'b0; in_valid = 1'b0;
		kind = '0; shaft_angle = '0; new_setpoint = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send(KIND_TICK, 14'h3FFF, '0);
		send(KIND_ENABLE, '0, '0);
		send(KIND_SETSPD, '0, 24'sh7FFFFF);
		send(KIND_TICK, 14'd0, '0);
		send(KIND_TICK, 14'd8192, '0);
		send(KIND_TICK, 14'd0, '0);
		send(KIND_TICK, 14'd8193, '0);
		send(KIND_TICK, 14'd1, '0);
		send(KIND_SETSPD, 14'h3FFF, 24'sh800000);
		send(KIND_TICK, 14'h3FFF, '0);
		send(KIND_TICK, 14'h2AAA, '0);
		send(KIND_TICK, 14'h1555, '0);
		send(3'd7, 14'h3FFF, 24'shFFFFFF);
		send(3'd5, '0, '0);
		send(KIND_DISABLE, '0, '0);
		send(KIND_TICK, 14'd100, '0);
		drain();
		for (int ph = 1; ph <= 6; ph++) begin
			random_regs(ph);
			if (ph == 2) begin
				send(KIND_ENABLE, '0, '0);
				send(KIND_SETSPD, '0, 24'sd50000);
				send(KIND_TICK, 14'd10, '0);
			end
			for (int n = 0; n < 260; n++) begin
				if (ph == 6 && n == 200) send(KIND_ESTOP, 14'($urandom), 24'($urandom));
				random_item();
			end
			drain();
		end
		send(KIND_ESTOP, '0, '0);
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end
endmodule
